// ===== rtl/assert_macros.svh =====
// Assertion macros for the normal CDF block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NCDF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ncdf check failed");
`define NCDF_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("ncdf check failed");
`else
`define NCDF_ASSERT(label, prop)
`define NCDF_NEVER(label, expr)
`endif
`endif

// ===== rtl/ncdf_pkg.sv =====
// Constants, widths and helpers for the normal CDF pipeline.
package ncdf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int X_W       = 20;
  localparam int PROB_W    = FRAC_BITS + 1;
  localparam int WB        = 30;
  localparam int N_TERMS   = 12;

  localparam logic [63:0] ONE_W  = 64'd1 << WB;
  localparam logic [63:0] HALF_W = 64'd1 << (WB - 1);

  localparam logic [63:0] P_CONST   = ((64'd2316419 << WB) + 64'd5000000) / 64'd10000000;
  localparam logic [63:0] C_CONST   = ((64'd39894228 << WB) + 64'd50000000) / 64'd100000000;
  localparam logic [63:0] LN2_CONST =
    ((64'd6931471806 << WB) + 64'd5000000000) / 64'd10000000000;

  localparam logic [63:0] COEF_MAG [5] = '{
    ((64'd319381530 << WB) + 64'd500000000) / 64'd1000000000,
    ((64'd356563782 << WB) + 64'd500000000) / 64'd1000000000,
    ((64'd1781477937 << WB) + 64'd500000000) / 64'd1000000000,
    ((64'd1821255978 << WB) + 64'd500000000) / 64'd1000000000,
    ((64'd1330274429 << WB) + 64'd500000000) / 64'd1000000000
  };
  localparam logic [4:0] COEF_NEG = 5'b01010;

  localparam int P_CW  = 28;
  localparam int C_CW  = 29;
  localparam int PA_W  = P_CW + X_W;
  localparam int D_W   = 32;
  localparam int Q_W   = WB + 1;
  localparam int ACC_W = 34;
  localparam int SQ_W  = 2 * X_W;
  localparam int H_SH  = 2 * FRAC_BITS - WB + 1;
  localparam int H_W   = SQ_W - H_SH;
  localparam int K_W   = 6;
  localparam int R_W   = WB;
  localparam int E_W   = WB + 1;
  localparam int QP_W  = WB + 1;
  localparam int M_W   = 32;
  localparam int N1_W  = WB;
  localparam int PRB_W = ACC_W - 1;
  localparam int RES_W = PRB_W - (WB - FRAC_BITS);
  localparam int K_BIG = 62;

  function automatic logic signed [ACC_W-1:0] coef_s(input int idx);
    logic signed [ACC_W-1:0] mag;
    mag = ACC_W'(COEF_MAG[idx]);
    return COEF_NEG[idx] ? -mag : mag;
  endfunction

endpackage

// ===== rtl/normal_cdf_polynomial_approx.sv =====
// Standard normal CDF pipeline, five-term polynomial approximation, Q4.16 in, Q1.16 out.
// One word enters per clock and busy stays low; each result appears on probability with
// done high for one cycle and cannot be held off. The depth is set by the exponential
// path: input, square and rounding (3 stages), the 6-stage range reduction, the 12-term
// series (4 stages per term), 3 stages of scaling by 2^-k and by c, and 4 stages for the
// product with the polynomial, the tail select and the output rounding. The 31-stage
// bit-per-stage reciprocal divider and the Horner chain run beside it and are delayed to
// meet it.
`include "assert_macros.svh"

module normal_cdf_polynomial_approx
  import ncdf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [X_W-1:0]    sample_x,
  output logic                     done,
  output logic [PROB_W-1:0]        probability
);

  localparam int DIV_STEPS = Q_W;
  localparam int POLY_LAT  = 2 + DIV_STEPS + 10;
  localparam int EXP_LAT   = 2 + K_W + 4 * N_TERMS + 1 + 2;
  localparam int DLY       = EXP_LAT - POLY_LAT;
  localparam int LATENCY   = EXP_LAT + 5;
  localparam int TS        = 4 * N_TERMS;

  typedef struct packed {
    logic           valid;
    logic           neg;
    logic [K_W-1:0] k;
    logic [R_W-1:0] r;
  } side_t;

  assign busy = 1'b0;

  // input stage
  logic            s0_valid;
  logic            s0_neg;
  logic [X_W-1:0]  s0_mag;
  logic [X_W-1:0]  x_u;

  assign x_u = sample_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_neg <= x_u[X_W-1];
    s0_mag <= x_u[X_W-1] ? X_W'(~x_u + 1'b1) : x_u;
  end

  // reciprocal path
  logic [PA_W-1:0] pa_prod;
  logic [PA_W-1:0] pa_sum;
  logic [D_W-1:0]  dv  [0:DIV_STEPS-1];
  logic [D_W-1:0]  rem [0:DIV_STEPS-1];
  logic [Q_W-1:0]  qt  [0:DIV_STEPS];

  assign pa_sum = pa_prod + PA_W'(1 << (FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    pa_prod <= P_CONST[P_CW-1:0] * s0_mag;
    dv[0]   <= D_W'(ONE_W) + pa_sum[FRAC_BITS +: D_W];
    rem[0]  <= D_W'(1) << (WB - 1);
    qt[0]   <= '0;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int BI = DIV_STEPS - 1 - j;
    logic [D_W:0] trial;
    logic [D_W:0] diff;
    logic         ge;

    assign trial = {rem[j], dv[j][BI+1]};
    assign diff  = trial - {1'b0, dv[j]};
    assign ge    = trial >= {1'b0, dv[j]};

    always_ff @(posedge clk) begin
      qt[j+1] <= {qt[j][Q_W-2:0], ge};
    end

    if (j < DIV_STEPS - 1) begin : g_adv
      always_ff @(posedge clk) begin
        rem[j+1] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        dv[j+1]  <= dv[j];
      end
    end
  end

  // Horner chain on t
  logic [63:0]             ha_prod [0:4];
  logic                    ha_neg  [0:4];
  logic [Q_W-1:0]          tm      [0:3];
  logic [Q_W-1:0]          tr      [0:3];
  logic signed [ACC_W-1:0] acc     [0:3];
  logic [PRB_W-1:0]        poly;

  for (genvar h = 0; h < 5; h++) begin : g_horn
    logic signed [ACC_W-1:0] acc_in;
    logic [Q_W-1:0]          t_in;
    logic                    a_neg;
    logic [ACC_W-2:0]        a_mag;
    logic [63:0]             hsum;
    logic [ACC_W-1:0]        rnd;
    logic signed [ACC_W-1:0] sr;

    if (h == 0) begin : g_first
      assign acc_in = coef_s(4);
      assign t_in   = qt[DIV_STEPS];
    end else begin : g_next
      assign acc_in = acc[h-1];
      assign t_in   = tr[h-1];
    end

    assign a_neg = acc_in[ACC_W-1];
    assign a_mag = a_neg ? (ACC_W-1)'(-acc_in) : acc_in[ACC_W-2:0];
    assign hsum  = ha_prod[h] + HALF_W;
    assign rnd   = hsum[WB +: ACC_W];
    assign sr    = ha_neg[h] ? -signed'(rnd) : signed'(rnd);

    always_ff @(posedge clk) begin
      ha_prod[h] <= a_mag * t_in;
      ha_neg[h]  <= a_neg;
    end

    if (h < 4) begin : g_add
      always_ff @(posedge clk) begin
        tm[h]  <= t_in;
        tr[h]  <= tm[h];
        acc[h] <= sr + coef_s(3 - h);
      end
    end else begin : g_clamp
      always_ff @(posedge clk) begin
        poly <= sr[ACC_W-1] ? '0 : sr[PRB_W-1:0];
      end
    end
  end

  // align poly with the exponential path
  logic [PRB_W-1:0] pd [0:DLY-1];

  always_ff @(posedge clk) begin
    pd[0] <= poly;
  end

  for (genvar i = 1; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      pd[i] <= pd[i-1];
    end
  end

  // square and range reduction
  logic            e1_valid;
  logic            e1_neg;
  logic [SQ_W-1:0] sq;
  logic [SQ_W-1:0] sq_sum;
  logic            kv [0:K_W];
  logic            kn [0:K_W];
  logic [H_W-1:0]  kr [0:K_W];
  logic [K_W-1:0]  kq [0:K_W];

  assign sq_sum = sq + SQ_W'(1 << (H_SH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      kv[0]    <= 1'b0;
    end else begin
      e1_valid <= s0_valid;
      kv[0]    <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    e1_neg <= s0_neg;
    sq     <= s0_mag * s0_mag;
    kn[0]  <= e1_neg;
    kr[0]  <= sq_sum[SQ_W-1:H_SH];
    kq[0]  <= '0;
  end

  for (genvar j = 0; j < K_W; j++) begin : g_kdiv
    localparam logic [H_W-1:0] LN2_SH = H_W'(LN2_CONST << (K_W - 1 - j));
    logic ge;

    assign ge = kr[j] >= LN2_SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        kv[j+1] <= 1'b0;
      end else begin
        kv[j+1] <= kv[j];
      end
    end

    always_ff @(posedge clk) begin
      kn[j+1] <= kn[j];
      kr[j+1] <= ge ? kr[j] - LN2_SH : kr[j];
      kq[j+1] <= {kq[j][K_W-2:0], ge};
    end
  end

  // exp(-r) series, four stages per term
  side_t side0;
  side_t side [1:TS];

  assign side0 = '{valid: kv[K_W], neg: kn[K_W], k: kq[K_W], r: kr[K_W][R_W-1:0]};

  for (genvar j = 0; j < TS; j++) begin : g_side
    side_t s_in;

    if (j == 0) begin : g_first
      assign s_in = side0;
    end else begin : g_next
      assign s_in = side[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        side[j+1] <= '0;
      end else begin
        side[j+1] <= s_in;
      end
    end
  end

  logic [R_W+E_W-1:0] ta [0:N_TERMS-1];
  logic [QP_W-1:0]    tb [0:N_TERMS-1];
  logic [QP_W+M_W-1:0] tc [0:N_TERMS-1];
  logic [E_W-1:0]     te [0:N_TERMS-1];

  for (genvar m = 0; m < N_TERMS; m++) begin : g_term
    localparam int NN = N_TERMS - m;
    localparam int LG = $clog2(NN);
    localparam int SH = QP_W + LG;
    localparam logic [63:0] MR = ((64'd1 << SH) + 64'(NN) - 64'd1) / 64'(NN);
    logic [R_W-1:0]     r_in;
    logic [E_W-1:0]     e_in;
    logic [R_W+E_W-1:0] asum;

    if (m == 0) begin : g_first
      assign r_in = side0.r;
      assign e_in = E_W'(ONE_W);
    end else begin : g_next
      assign r_in = side[4*m].r;
      assign e_in = te[m-1];
    end

    assign asum = ta[m] + (R_W+E_W)'(HALF_W);

    always_ff @(posedge clk) begin
      ta[m] <= r_in * e_in;
      tb[m] <= asum[WB +: QP_W] + QP_W'(NN / 2);
      tc[m] <= tb[m] * MR[M_W-1:0];
      te[m] <= E_W'(ONE_W) - E_W'(tc[m] >> SH);
    end
  end

  // scale by 2^-k, then by c
  side_t             st;
  logic [E_W-1:0]    sh1;
  logic [E_W:0]      sh_p1;
  logic [E_W-1:0]    es;
  logic [C_CW+E_W-1:0] cm_prod;
  logic [C_CW+E_W-1:0] cm_sum;
  logic [N1_W-1:0]   n1;
  logic              tv [0:5];
  logic              tn [0:4];

  assign st     = side[TS];
  assign sh1    = te[N_TERMS-1] >> (st.k - 1'b1);
  assign sh_p1  = {1'b0, sh1} + 1'b1;
  assign cm_sum = cm_prod + (C_CW+E_W)'(HALF_W);

  always_ff @(posedge clk) begin
    if (st.k == '0) begin
      es <= te[N_TERMS-1];
    end else if (st.k >= K_W'(K_BIG)) begin
      es <= '0;
    end else begin
      es <= sh_p1[E_W:1];
    end
    cm_prod <= C_CONST[C_CW-1:0] * es;
    n1      <= cm_sum[WB +: N1_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv[0] <= 1'b0;
    end else begin
      tv[0] <= st.valid;
    end
    tn[0] <= st.neg;
  end

  for (genvar i = 1; i < 6; i++) begin : g_tail
    always_ff @(posedge clk) begin
      if (rst) begin
        tv[i] <= 1'b0;
      end else begin
        tv[i] <= tv[i-1];
      end
    end
    if (i < 5) begin : g_neg
      always_ff @(posedge clk) begin
        tn[i] <= tn[i-1];
      end
    end
  end

  // combine, select tail, round
  logic [N1_W+PRB_W-1:0] fm;
  logic [N1_W+PRB_W-1:0] fm_sum;
  logic [PRB_W-1:0]      nn;
  logic [PRB_W-1:0]      prob;
  logic [PRB_W-1:0]      p_sum;
  logic [RES_W-1:0]      res;

  assign fm_sum = fm + (N1_W+PRB_W)'(HALF_W);
  assign p_sum  = prob + PRB_W'(1 << (WB - FRAC_BITS - 1));
  assign res    = p_sum[WB-FRAC_BITS +: RES_W];

  always_ff @(posedge clk) begin
    fm <= n1 * pd[DLY-1];
    nn <= fm_sum[WB +: PRB_W];
    if (tn[4]) begin
      prob <= nn;
    end else if (nn >= PRB_W'(ONE_W)) begin
      prob <= '0;
    end else begin
      prob <= PRB_W'(ONE_W) - nn;
    end
    if (res > RES_W'(1 << FRAC_BITS)) begin
      probability <= PROB_W'(1 << FRAC_BITS);
    end else begin
      probability <= res[PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tv[5];
    end
  end

  `NCDF_NEVER(a_range, done && (probability > PROB_W'(1 << FRAC_BITS)))
  `NCDF_ASSERT(a_lat, (start && !busy) |-> ##LATENCY done)
  `NCDF_ASSERT(a_src, done |-> $past(start && !busy, LATENCY))

endmodule

// ===== tb/sv/normal_cdf_polynomial_approx_tb.sv =====
// Self-checking testbench for the normal CDF pipeline: directed table, then random words.
module normal_cdf_polynomial_approx_tb
  import ncdf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int N_RANDOM       = 1200;
  localparam int N_TABLE        = 16;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic signed [X_W-1:0] sample_x;
  logic                  done;
  logic [PROB_W-1:0]     probability;

  logic [PROB_W-1:0] expected_prob_q[$];
  int                error_count;
  int                idle_cycles;
  int                idle_pct;

  normal_cdf_polynomial_approx DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_x(sample_x), .done(done), .probability(probability)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b + HALF_W) >> WB;
  endfunction

  function automatic longint smul_q30(input longint s, input logic [63:0] t);
    logic [63:0] m;
    logic [63:0] r;
    m = (s < 0) ? 64'(-s) : 64'(s);
    r = mul_q30(m, t);
    return (s < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint coef_q30(input int i);
    return COEF_NEG[i] ? -longint'(COEF_MAG[i]) : longint'(COEF_MAG[i]);
  endfunction

  function automatic logic [63:0] gauss_factor(input logic [63:0] h);
    logic [63:0] k;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] q;
    k = h / LN2_CONST;
    r = h - k * LN2_CONST;
    e = ONE_W;
    for (int n = N_TERMS; n >= 1; n--) begin
      q = mul_q30(r, e);
      q = (q + 64'(n / 2)) / 64'(n);
      e = ONE_W - q;
    end
    if (k >= K_BIG) return 64'd0;
    if (k == 0) return e;
    return (e + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic [PROB_W-1:0] cdf_of(input logic signed [X_W-1:0] x);
    logic [63:0] mag;
    logic [63:0] d;
    logic [63:0] t;
    logic [63:0] h;
    logic [63:0] n;
    logic [63:0] prob;
    logic [63:0] res;
    longint      acc;
    mag = x[X_W-1] ? 64'(-65'(x)) : 64'(x);
    d = ONE_W + ((P_CONST * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    t = ((ONE_W << WB) + d / 2) / d;
    acc = coef_q30(4);
    for (int i = 3; i >= 0; i--) acc = smul_q30(acc, t) + coef_q30(i);
    acc = smul_q30(acc, t);
    if (acc < 0) acc = 0;
    h = (mag * mag + (64'd1 << (2 * FRAC_BITS - WB))) >> (2 * FRAC_BITS - WB + 1);
    n = mul_q30(mul_q30(C_CONST, gauss_factor(h)), 64'(acc));
    if (x[X_W-1]) prob = n;
    else prob = (n >= ONE_W) ? 64'd0 : ONE_W - n;
    res = (prob + (64'd1 << (WB - FRAC_BITS - 1))) >> (WB - FRAC_BITS);
    if (res > (64'd1 << FRAC_BITS)) res = 64'd1 << FRAC_BITS;
    return res[PROB_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [PROB_W-1:0] got,
                                 input logic [PROB_W-1:0] want);
    $display("mismatch %s: probability got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // directed rows; exp_known marks a value readable without the predictor
  typedef struct {
    logic signed [X_W-1:0] x;
    logic                  exp_known;
    logic [PROB_W-1:0]     prob;
  } cdf_row_t;

  cdf_row_t cdf_table[N_TABLE];

  initial begin
    cdf_table[0]  = '{20'sh80000, 1'b1, 17'd0};
    cdf_table[1]  = '{20'sh7FFFF, 1'b1, 17'd65536};
    cdf_table[2]  = '{20'sh00000, 1'b0, 17'd0};
    cdf_table[3]  = '{20'sh00001, 1'b0, 17'd0};
    cdf_table[4]  = '{20'shFFFFF, 1'b0, 17'd0};
    cdf_table[5]  = '{20'sh10000, 1'b0, 17'd0};
    cdf_table[6]  = '{20'shF0000, 1'b0, 17'd0};
    cdf_table[7]  = '{20'sh20000, 1'b0, 17'd0};
    cdf_table[8]  = '{20'shE0000, 1'b0, 17'd0};
    cdf_table[9]  = '{20'sh40000, 1'b0, 17'd0};
    cdf_table[10] = '{20'shC0000, 1'b0, 17'd0};
    cdf_table[11] = '{20'sh80001, 1'b0, 17'd0};
    cdf_table[12] = '{20'sh55555, 1'b0, 17'd0};
    cdf_table[13] = '{20'shAAAAA, 1'b0, 17'd0};
    cdf_table[14] = '{20'sh08000, 1'b0, 17'd0};
    cdf_table[15] = '{20'shF8000, 1'b0, 17'd0};
  end

  task automatic send_word(input logic signed [X_W-1:0] x, input logic [PROB_W-1:0] want);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    sample_x <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_prob_q.push_back(want);
  endtask

  task automatic idle_line();
    start    <= 1'b0;
    sample_x <= X_W'($urandom);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_prob_q.size() == 0) begin
        report_mismatch("unexpected word", probability, '0);
      end else if (probability !== expected_prob_q[0]) begin
        report_mismatch("probability", probability, expected_prob_q.pop_front());
      end else begin
        void'(expected_prob_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    logic signed [X_W-1:0] x;
    int                    wait_cnt;
    rst         = 1'b1;
    start       = 1'b0;
    sample_x    = '0;
    idle_pct    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < N_TABLE; i++) begin
      send_word(cdf_table[i].x,
                cdf_table[i].exp_known ? cdf_table[i].prob : cdf_of(cdf_table[i].x));
    end
    idle_line();
    while (expected_prob_q.size() != 0) @(posedge clk);
    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 4) / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 79;
        2: idle_pct = 21;
        default: idle_pct = (i % 100 < 30) ? 0 : 79;
      endcase
      // hold off until the pipeline drains
      if (i == N_RANDOM / 2) begin
        idle_line();
        while (expected_prob_q.size() != 0) @(posedge clk);
      end
      case ($urandom_range(3, 0))
        0: x = X_W'($urandom);
        1: x = X_W'($urandom_range(24 * 65536, 0)) - X_W'(12 * 65536);
        2: x = X_W'($urandom_range(8191, 0)) - X_W'(4096);
        default: x = X_W'($urandom_range(6 * 65536, 0)) - X_W'(3 * 65536);
      endcase
      send_word(x, cdf_of(x));
    end
    idle_line();
    while (expected_prob_q.size() != 0) @(posedge clk);
    wait_cnt = 0;
    while (wait_cnt < DRAIN_CYCLES) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (error_count == 0 && expected_prob_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
